>>> sv/spq_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the sorted priority queue
package spq_pkg;

	localparam int DEPTH_DEF       = 16;
	localparam int VALUE_WIDTH_DEF = 32;

	// fixed widths of the channel fields
	localparam int OP_W    = 3;
	localparam int ITEM_W  = 32;
	localparam int POS_W   = 4;
	localparam int COUNT_W = 5;

	typedef enum logic [OP_W-1:0] {
		OP_OFFER     = 3'd0,
		OP_PEEK      = 3'd1,
		OP_POLL      = 3'd2,
		OP_AT        = 3'd3,
		OP_REMOVE    = 3'd4,
		OP_REMOVE_AT = 3'd5,
		OP_CLEAR     = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [ITEM_W-1:0]  result_value;
		logic               found;
		logic [POS_W-1:0]   insert_position;
		logic [COUNT_W-1:0] removed_count;
		logic               rejected;
		logic [COUNT_W-1:0] occupancy;
	} rsp_t;

endpackage

>>> sv/spq_ifs.sv
`timescale 1ns / 1ps
// command, response and configuration channels of the sorted priority queue

interface spq_cmd_if;
	import spq_pkg::*;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   opcode;
	logic [ITEM_W-1:0] item_value;
	logic [POS_W-1:0]  position_in;
	modport source(output valid, output opcode, output item_value, output position_in,
		input ready);
	modport sink(input valid, input opcode, input item_value, input position_in,
		output ready);
endinterface

interface spq_rsp_if;
	import spq_pkg::*;
	logic               valid;
	logic               ready;
	logic [ITEM_W-1:0]  result_value;
	logic               found;
	logic [POS_W-1:0]   insert_position;
	logic [COUNT_W-1:0] removed_count;
	logic               rejected;
	logic [COUNT_W-1:0] occupancy;
	modport source(output valid, output result_value, output found, output insert_position,
		output removed_count, output rejected, output occupancy, input ready);
	modport sink(input valid, input result_value, input found, input insert_position,
		input removed_count, input rejected, input occupancy, output ready);
endinterface

interface spq_cfg_if;
	logic valid;
	logic ready;
	logic data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> sv/sorted_priority_queue.sv
`timescale 1ns / 1ps
// Sorted priority queue of DEPTH value words held in one single-port-read memory, head at
// entry 0, ordered smallest first or, with the descending register set, largest first.
// One item is worked at a time. The memory read port walks the entries one per cycle,
// moving entries up or down as it goes: offer and remove value walk the whole queue, poll
// and remove at walk from the index to the end, and peek and at read a single entry;
// clear, rejected offers, misses and remove value on an empty queue skip the walk.
// The next item is accepted on the edge after the result is registered, even while that
// result still waits in the output register; a stalled output holds the next result back.
module sorted_priority_queue #(
	parameter int DEPTH       = spq_pkg::DEPTH_DEF,
	parameter int VALUE_WIDTH = spq_pkg::VALUE_WIDTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	spq_cmd_if.sink   cmd,
	spq_rsp_if.source rsp,
	spq_cfg_if.sink   cfg
);
	import spq_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

	logic [VALUE_WIDTH-1:0] mem [DEPTH];

	state_t state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic             desc_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic [OP_W-1:0]        op_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [IDX_W-1:0]       pos_q;
	logic [CNT_W-1:0]       rd_q, lim_q, wr_q, rm_q;
	logic                   hit_q;
	logic [IDX_W-1:0]       at_q;
	logic [VALUE_WIDTH-1:0] carry_q, res_q;
	logic                   found_q, rej_q;

	logic                   rvalid_s1;
	logic [IDX_W-1:0]       ridx_s1;
	logic [VALUE_WIDTH-1:0] rdata_s1;

	logic cmd_fire, issue, load_rsp, start_scan, pos_ok, ahead;
	logic                   mem_we;
	logic [IDX_W-1:0]       mem_waddr;
	logic [VALUE_WIDTH-1:0] mem_wdata;
	logic [IDX_W-1:0]       pos_c;
	logic [CNT_W-1:0]       rd_c, lim_c;

	assign cmd_fire = cmd.valid && cmd.ready;
	assign cfg.ready = 1'b1;
	assign pos_ok = 32'(cmd.position_in) < 32'(count_q);
	assign ahead = desc_q ? (val_q >= rdata_s1) : (val_q <= rdata_s1);

	// scan setup decoded from the incoming item
	always_comb begin
		start_scan = 1'b0;
		pos_c = '0;
		rd_c = '0;
		lim_c = count_q;
		unique case (cmd.opcode)
			OP_OFFER: start_scan = count_q < CNT_MAX;
			OP_PEEK: begin
				start_scan = count_q != '0;
				lim_c = CNT_ONE;
			end
			OP_POLL, OP_REMOVE: start_scan = count_q != '0;
			OP_AT: begin
				start_scan = pos_ok;
				pos_c = IDX_W'(cmd.position_in);
				rd_c = CNT_W'(pos_c);
				lim_c = CNT_W'(pos_c) + CNT_ONE;
			end
			OP_REMOVE_AT: begin
				start_scan = pos_ok;
				pos_c = IDX_W'(cmd.position_in);
				rd_c = CNT_W'(pos_c);
			end
			default: start_scan = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (cmd_fire) begin
				state_d = start_scan ? ST_SCAN : ST_DONE;
			end
			ST_SCAN: if (rd_q == lim_q && !rvalid_s1) begin
				state_d = ST_FINISH;
			end
			ST_FINISH: state_d = ST_DONE;
			ST_DONE: if (!rsp_valid_q || rsp.ready) begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		cmd.ready = 1'b0;
		issue = 1'b0;
		load_rsp = 1'b0;
		unique case (state_q)
			ST_IDLE: cmd.ready = 1'b1;
			ST_SCAN: issue = rd_q < lim_q;
			ST_DONE: load_rsp = !rsp_valid_q || rsp.ready;
			default: issue = 1'b0;
		endcase
	end

	// memory write: shift for offer, compaction for the removals
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = ridx_s1;
		mem_wdata = rdata_s1;
		if (rvalid_s1) begin
			unique case (op_q)
				OP_OFFER: begin
					mem_we = hit_q || ahead;
					mem_wdata = hit_q ? carry_q : val_q;
				end
				OP_POLL, OP_REMOVE_AT: begin
					mem_we = ridx_s1 != pos_q;
					mem_waddr = wr_q[IDX_W-1:0];
				end
				OP_REMOVE: begin
					mem_we = rdata_s1 != val_q;
					mem_waddr = wr_q[IDX_W-1:0];
				end
				default: mem_we = 1'b0;
			endcase
		end else if (state_q == ST_FINISH && op_q == OP_OFFER) begin
			mem_we = 1'b1;
			mem_waddr = count_q[IDX_W-1:0];
			mem_wdata = hit_q ? carry_q : val_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (issue) begin
			rdata_s1 <= mem[rd_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			desc_q <= 1'b0;
			rvalid_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rvalid_s1 <= issue;
			if (cfg.valid) begin
				desc_q <= cfg.data;
			end
			if (cmd_fire && cmd.opcode == OP_CLEAR) begin
				count_q <= '0;
			end else if (state_q == ST_FINISH) begin
				unique case (op_q)
					OP_OFFER: count_q <= count_q + CNT_ONE;
					OP_POLL, OP_REMOVE_AT: count_q <= count_q - CNT_ONE;
					OP_REMOVE: count_q <= wr_q;
					default: count_q <= count_q;
				endcase
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			ridx_s1 <= rd_q[IDX_W-1:0];
			rd_q <= rd_q + CNT_ONE;
		end
		if (cmd_fire) begin
			op_q <= cmd.opcode;
			val_q <= VALUE_WIDTH'(cmd.item_value);
			pos_q <= pos_c;
			rd_q <= rd_c;
			wr_q <= rd_c;
			lim_q <= lim_c;
			rm_q <= '0;
			hit_q <= 1'b0;
			at_q <= '0;
			res_q <= '0;
			found_q <= 1'b0;
			rej_q <= cmd.opcode == OP_OFFER && count_q == CNT_MAX;
		end else if (rvalid_s1) begin
			unique case (op_q)
				OP_OFFER: begin
					if (hit_q) begin
						carry_q <= rdata_s1;
					end else if (ahead) begin
						hit_q <= 1'b1;
						at_q <= ridx_s1;
						carry_q <= rdata_s1;
					end
				end
				OP_PEEK, OP_AT: begin
					res_q <= rdata_s1;
					found_q <= 1'b1;
				end
				OP_POLL, OP_REMOVE_AT: begin
					if (ridx_s1 == pos_q) begin
						res_q <= rdata_s1;
					end else begin
						wr_q <= wr_q + CNT_ONE;
					end
				end
				OP_REMOVE: begin
					if (rdata_s1 == val_q) begin
						rm_q <= rm_q + CNT_ONE;
					end else begin
						wr_q <= wr_q + CNT_ONE;
					end
				end
				default: found_q <= found_q;
			endcase
		end else if (state_q == ST_FINISH) begin
			unique case (op_q)
				OP_OFFER: begin
					found_q <= 1'b1;
					if (!hit_q) begin
						at_q <= count_q[IDX_W-1:0];
					end
				end
				OP_POLL, OP_REMOVE_AT: found_q <= 1'b1;
				default: found_q <= found_q;
			endcase
		end
		if (load_rsp) begin
			rsp_q.result_value <= ITEM_W'(res_q);
			rsp_q.found <= found_q;
			rsp_q.insert_position <= POS_W'(at_q);
			rsp_q.removed_count <= COUNT_W'(rm_q);
			rsp_q.rejected <= rej_q;
			rsp_q.occupancy <= COUNT_W'(count_q);
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.result_value = rsp_q.result_value;
	assign rsp.found = rsp_q.found;
	assign rsp.insert_position = rsp_q.insert_position;
	assign rsp.removed_count = rsp_q.removed_count;
	assign rsp.rejected = rsp_q.rejected;
	assign rsp.occupancy = rsp_q.occupancy;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("occupancy beyond depth");

	a_read_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> rd_q <= lim_q)
		else $error("read pointer past scan limit");

	a_compact_behind: assert property (@(posedge clk) disable iff (!arst_n)
		rvalid_s1 && (op_q == OP_POLL || op_q == OP_REMOVE_AT || op_q == OP_REMOVE)
		|-> wr_q <= CNT_W'(ridx_s1))
		else $error("compaction write ahead of read");

	a_full_reject: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire && cmd.opcode == OP_OFFER && count_q == CNT_MAX |=> state_q == ST_DONE)
		else $error("offer on full queue started a scan");

	a_write_window: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> state_q == ST_SCAN || state_q == ST_FINISH)
		else $error("memory write outside scan");
`endif

endmodule
